// File: hdl/fpcm_pkg.sv
// ----------------------------------------------------------------------------
// fpcm_pkg: shared types and constants
// Sample format codes, lane control struct and scale tables.
// ----------------------------------------------------------------------------
package fpcm_pkg;

   typedef enum logic [1:0] {
      FMT_FLOAT32 = 2'd0,
      FMT_PCM16   = 2'd1,
      FMT_PCM24   = 2'd2,
      FMT_PCM32   = 2'd3
   } fmt_type;

   localparam int SAMPLE_W = 32;
   localparam int SIG_W    = 24;
   localparam int SCALE_W  = 32;
   localparam int PROD_W   = SIG_W + SCALE_W;

   localparam logic [30:0] MAG_ONE = 31'h3F800000;
   localparam logic [30:0] MAG_INF = 31'h7F800000;

   // per-lane stage-1 result passed to the rounding stage
   typedef struct packed {
      logic                 pass;
      logic                 sat;
      logic                 neg;
      logic [7:0]           ex;
      logic [SAMPLE_W-1:0]  bits;
   } lane_ctl_type;

   function automatic logic [SCALE_W-1:0] scale_of(fmt_type f);
      logic [SCALE_W-1:0] s;
      unique case (f)
         FMT_PCM16: s = 32'd32767;
         FMT_PCM24: s = 32'd8388607;
         FMT_PCM32: s = 32'h80000000;
         default:   s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [SCALE_W-1:0] pos_max_of(fmt_type f);
      logic [SCALE_W-1:0] s;
      unique case (f)
         FMT_PCM16: s = 32'd32767;
         FMT_PCM24: s = 32'd8388607;
         FMT_PCM32: s = 32'h7FFFFFFF;
         default:   s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [SAMPLE_W-1:0] mask_of(fmt_type f);
      logic [SAMPLE_W-1:0] m;
      unique case (f)
         FMT_PCM16: m = 32'h0000FFFF;
         FMT_PCM24: m = 32'h00FFFFFF;
         default:   m = 32'hFFFFFFFF;
      endcase
      return m;
   endfunction

endpackage

// File: hdl/fpcm_lane.sv
// ----------------------------------------------------------------------------
// fpcm_lane: one channel's converter
// Three stages: classify and multiply, round the product to float precision,
// then round to integer and apply sign and format mask.
// ----------------------------------------------------------------------------
module fpcm_lane (
   input  logic                     clock,
   input  logic                     advance,
   input  fpcm_pkg::fmt_type        fmt,
   input  logic [31:0]              sample,
   output logic [31:0]              code
);
   import fpcm_pkg::*;

   lane_ctl_type         ctl_ff, ctl_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   fmt_type              fmt_ff;
   lane_ctl_type         rctl_ff;
   logic [PROD_W-1:0]    rp_ff, rp_in;
   fmt_type              rfmt_ff;
   logic [SAMPLE_W-1:0]  code_ff, code_in;

   always_comb begin
      logic [30:0]       mag;
      logic [SIG_W-1:0]  sig;
      mag = sample[30:0];
      sig = {(mag[30:23] != 8'd0), mag[22:0]};
      ctl_in.pass = (fmt == FMT_FLOAT32);
      ctl_in.bits = sample;
      ctl_in.ex   = (mag[30:23] == 8'd0) ? 8'd1 : mag[30:23];
      ctl_in.sat  = (mag >= MAG_ONE);
      // NaN goes to plus one
      ctl_in.neg  = sample[31] && !(mag > MAG_INF);
      prod_in     = PROD_W'(sig) * PROD_W'(scale_of(fmt));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff  <= ctl_in;
         prod_ff <= prod_in;
         fmt_ff  <= fmt;
      end
   end

   // round the product to 24 significant bits
   always_comb begin
      logic [5:0]        len;
      logic [5:0]        sh;
      logic [PROD_W-1:0] rem, half, q;
      len  = '0;
      sh   = '0;
      rem  = '0;
      half = '0;
      q    = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (prod_ff[i]) len = 6'(i + 1);
      end
      rp_in = prod_ff;
      if (len > 6'd24) begin
         sh   = len - 6'd24;
         q    = prod_ff >> sh;
         rem  = prod_ff & ((PROD_W'(1) << sh) - PROD_W'(1));
         half = PROD_W'(1) << (sh - 6'd1);
         if (rem > half || (rem == half && q[0])) q = q + PROD_W'(1);
         rp_in = q << sh;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rctl_ff <= ctl_ff;
         rp_ff   <= rp_in;
         rfmt_ff <= fmt_ff;
      end
   end

   always_comb begin
      logic [PROD_W-1:0] rem, half, q, n;
      logic [7:0]        drop;
      rem  = '0;
      half = '0;
      q    = '0;
      drop = 8'd150 - rctl_ff.ex;
      n = '0;
      // a drop this wide leaves at most one half, which rounds to zero
      if (drop < 8'(PROD_W)) begin
         q    = rp_ff >> drop;
         rem  = rp_ff & ((PROD_W'(1) << drop) - PROD_W'(1));
         half = PROD_W'(1) << (drop - 8'd1);
         if (rem > half || (rem == half && q[0])) q = q + PROD_W'(1);
         n = q;
      end
      if (rctl_ff.sat) begin
         n = rctl_ff.neg ? PROD_W'(scale_of(rfmt_ff)) : PROD_W'(pos_max_of(rfmt_ff));
      end
      if (rctl_ff.neg) n = PROD_W'(0) - n;
      code_in = rctl_ff.pass ? rctl_ff.bits : (n[SAMPLE_W-1:0] & mask_of(rfmt_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

// File: hdl/float_to_pcm_stereo_converter_core.sv
// ----------------------------------------------------------------------------
// float_to_pcm_stereo_converter_core: stereo float to PCM converter
// Two parallel lanes convert the left and right samples of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one stereo frame per item: tdata = {right, left} float bits,
//   tlast marks the final frame of a block. rsp_ returns one item per frame
//   with tdata = {right_code, left_code} and tlast copied.
//   csr_ writes the 2-bit sample format (0 float32, 1 PCM16, 2 PCM24,
//   3 PCM32); write it only while the block is idle.
//   The pipeline has four stages (multiply, float round, integer round,
//   output); one item is taken each cycle unless the pipeline holds as
//   described below.
//   When rsp_tready is low and the output register is full the whole
//   pipeline holds and req_tready drops; bubbles inside are not squeezed out.
//   Reset clears the valid bits and sets the format to float32.
// ----------------------------------------------------------------------------
module float_to_pcm_stereo_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // left_sample[31:0], right_sample[63:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // left_code[31:0], right_code[63:32]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);
   import fpcm_pkg::*;

   fmt_type    fmt_ff;
   logic [3:0] vld_ff;
   logic [3:0] last_ff;
   logic       advance;

   // pipeline moves when the output slot is empty or being taken
   assign advance    = !vld_ff[3] || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_FLOAT32;
         vld_ff <= '0;
      end else begin
         if (csr_valid) fmt_ff <= fmt_type'(csr_data);
         if (advance) vld_ff <= {vld_ff[2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) last_ff <= {last_ff[2:0], req_tlast};
   end

   logic [31:0] left_code, right_code;

   fpcm_lane u_left (
      .clock(clock), .advance(advance), .fmt(fmt_ff),
      .sample(req_tdata[31:0]), .code(left_code)
   );

   fpcm_lane u_right (
      .clock(clock), .advance(advance), .fmt(fmt_ff),
      .sample(req_tdata[63:32]), .code(right_code)
   );

   logic [63:0] data_ff;
   always_ff @(posedge clock) begin
      if (advance) data_ff <= {right_code, left_code};
   end

   // lanes already hold stage 3; merge into the output register
   assign rsp_tvalid = vld_ff[3];
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff[3];

endmodule

// File: test/tb_float_to_pcm_stereo_converter_core.sv
// ----------------------------------------------------------------------------
// tb_float_to_pcm_stereo_converter_core: converter testbench
// Drives stereo float frames through every sample format, predicts each
// converted frame with an integer model of the rounding, and checks results.
// ----------------------------------------------------------------------------
module tb_float_to_pcm_stereo_converter_core;
   import fpcm_pkg::*;

   typedef struct {
      logic [31:0] left_code;
      logic [31:0] right_code;
      logic        last;
   } frame_type;

   // round to nearest, ties to even, after dropping sh low bits
   function automatic logic [63:0] round_even(logic [63:0] v, int sh);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      q = v >> sh;
      rem = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [31:0] pcm_code(logic [31:0] bits, fmt_type f);
      logic        neg;
      logic [30:0] mag;
      logic [63:0] n;
      logic [63:0] scl;
      logic [63:0] pmax;
      logic [63:0] sig;
      logic [63:0] prod;
      logic [63:0] msk;
      int          ex;
      int          len;
      int          sh;
      neg = bits[31];
      mag = bits[30:0];
      if (f == FMT_FLOAT32) return bits;
      case (f)
         FMT_PCM16: begin scl = 32767; pmax = 32767; msk = 64'hFFFF; end
         FMT_PCM24: begin scl = 8388607; pmax = 8388607; msk = 64'hFFFFFF; end
         default: begin
            scl = 64'h80000000; pmax = 64'h7FFFFFFF; msk = 64'hFFFFFFFF;
         end
      endcase
      if (mag > 31'h7F800000) begin
         neg = 1'b0;
         n = pmax;
      end else if (mag >= 31'h3F800000) begin
         n = neg ? scl : pmax;
      end else begin
         ex = mag[30:23];
         sig = {41'd0, mag[22:0]};
         if (ex != 0) sig[23] = 1'b1;
         else ex = 1;
         prod = sig * scl;
         len = 0;
         for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
         if (len > 24) begin
            sh = len - 24;
            prod = round_even(prod, sh) << sh;
         end
         sh = 150 - ex;
         n = (sh >= 64) ? 64'd0 : round_even(prod, sh);
      end
      if (neg) n = 64'd0 - n;
      return n[31:0] & msk[31:0];
   endfunction

   class frame_scoreboard;
      frame_type pending[$];
      int        mismatches;
      int        checked;

      function void note_frame(logic [63:0] data, logic last, fmt_type f);
         frame_type e;
         e.left_code = pcm_code(data[31:0], f);
         e.right_code = pcm_code(data[63:32], f);
         e.last = last;
         pending.push_back(e);
      endfunction

      function void check_frame(logic [63:0] data, logic last);
         frame_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", data);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (data[31:0] !== e.left_code || data[63:32] !== e.right_code ||
               last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: exp L=%h R=%h last=%b got L=%h R=%h last=%b",
                  e.left_code, e.right_code, e.last, data[31:0], data[63:32], last);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_data = '0;

   frame_scoreboard board = new();
   fmt_type         cur_fmt = FMT_FLOAT32;
   int              cycles = 0;
   int              sent = 0;
   bit              drain_stall = 0;

   float_to_pcm_stereo_converter_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("ERROR: timeout");
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus long no-stall stretches
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_frame(rsp_tdata, rsp_tlast);
      if (reset) rsp_tready <= 1'b0;
      else if (drain_stall) rsp_tready <= ($urandom_range(0, 9) > 2);
      else rsp_tready <= 1'b1;
   end

   initial begin
      forever begin
         repeat ($urandom_range(20, 200)) @(posedge clock);
         drain_stall = ~drain_stall;
      end
   end

   task automatic set_format(fmt_type f);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= f;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_fmt = f;
   endtask

   task automatic send_frame(logic [31:0] l, logic [31:0] r, logic last, bit gaps);
      int n;
      n = gaps ? gap_len() : 0;
      // drop valid over the gap so the previous item is not taken again
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r, l};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_frame({r, l}, last, cur_fmt);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_sample();
      int k;
      logic [31:0] s;
      k = $urandom_range(0, 9);
      s = $urandom;
      case (k)
         0, 1: ;                                          // any pattern
         2, 3, 4: s[30:23] = $urandom_range(100, 126);     // inside (-1,1)
         5: s[30:23] = $urandom_range(0, 99);              // tiny and subnormal
         6: s[30:0] = 31'h3F800000 + $urandom_range(0, 3); // near one
         7: s[30:0] = 31'h3F7FFFFF - $urandom_range(0, 3);
         8: s[30:23] = 8'hFF;                              // inf and NaN
         default: s[30:23] = $urandom_range(110, 126);
      endcase
      return s;
   endfunction

   logic [31:0] edge_vals[16] = '{32'h00000000, 32'h80000000, 32'h3F800000,
      32'hBF800000, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
      32'h3F000000, 32'hBF000000, 32'h00000001, 32'h807FFFFF, 32'h3F7FFFFF,
      32'hBF7FFFFF, 32'h38000100, 32'h7F7FFFFF};

   initial begin
      bit gaps;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // default format is float32 passthrough
      for (int i = 0; i < 8; i++)
         send_frame(edge_vals[2*i], edge_vals[2*i+1], i[0], 1'b1);
      drain();
      for (int f = 3; f >= 0; f--) begin
         set_format(fmt_type'(f));
         for (int i = 0; i < 8; i++)
            send_frame(edge_vals[i], edge_vals[15-i], i[0], 1'b0);
         drain();
      end
      for (int ph = 0; ph < 12; ph++) begin
         set_format(fmt_type'($urandom_range(0, 3)));
         gaps = ph[0];
         for (int i = 0; i < 170; i++)
            send_frame(rand_sample(), rand_sample(), $urandom_range(0, 1),
               gaps || ($urandom_range(0, 3) == 0));
         drain();
      end
      repeat (10) @(posedge clock);
      $display("Sent %0d frames through all four formats, %0d results checked.",
         sent, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
